[rtl/mbd_pkg.sv]
package mbd_pkg;

   localparam int unsigned RAW_BITS      = 8;
   localparam int unsigned MASK_BITS     = 8;
   localparam int unsigned TONE_CH_BITS  = 3;
   localparam int unsigned TONE_HZ_BITS  = 11;
   localparam int unsigned DEBOUNCE_BITS = 16;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd8;

   // per-channel result handed to the top level
   typedef struct packed {
      logic stable;
      logic press;
   } chan_status_type;

   // tone frequency for a channel, low three bits of its number
   function automatic logic [TONE_HZ_BITS-1:0] tone_lookup(input logic [TONE_CH_BITS-1:0] ch);
      logic [TONE_HZ_BITS-1:0] hz;
      case (ch)
         3'd0:    hz = 11'd523;
         3'd1:    hz = 11'd587;
         3'd2:    hz = 11'd659;
         3'd3:    hz = 11'd698;
         3'd4:    hz = 11'd784;
         3'd5:    hz = 11'd880;
         3'd6:    hz = 11'd988;
         default: hz = 11'd1047;
      endcase
      return hz;
   endfunction

endpackage

[rtl/mbd_channel.sv]
module mbd_channel import mbd_pkg::*; #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [TIME_BITS-1:0]     now,
   input  logic                     raw,
   input  logic [DEBOUNCE_BITS-1:0] debounce_time,
   output chan_status_type          status
);

   localparam int unsigned CMP_BITS = (TIME_BITS > DEBOUNCE_BITS) ? TIME_BITS : DEBOUNCE_BITS;

   logic                 last_raw_ff;
   logic [TIME_BITS-1:0] stamp_ff;
   logic                 stable_ff;

   logic                 last_raw_in;
   logic [TIME_BITS-1:0] stamp_in;
   logic                 stable_in;
   logic [TIME_BITS-1:0] elapsed;
   logic                 settled;

   always_comb begin
      last_raw_in = raw;
      // a raw change restarts the hold time
      stamp_in    = (raw != last_raw_ff) ? now : stamp_ff;
      elapsed     = now - stamp_in;
      settled     = CMP_BITS'(elapsed) >= CMP_BITS'(debounce_time);
      stable_in   = settled ? raw : stable_ff;
      status.stable = stable_in;
      status.press  = settled && raw && !stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b0;
         stamp_ff    <= '0;
         stable_ff   <= 1'b0;
      end else if (step) begin
         last_raw_ff <= last_raw_in;
         stamp_ff    <= stamp_in;
         stable_ff   <= stable_in;
      end
   end

endmodule

[rtl/multi_button_debounce_press_event.sv]
// a request beat passes the input register, then the response register loaded from the
//   per-channel debounce logic, on its way to its response beat
// throughput: one sample per cycle while the response side does not stall
// reset: synchronous, active high; clears all channel state, both pipeline valids and loads
//   the debounce time with 8
module multi_button_debounce_press_event import mbd_pkg::*; #(
   parameter int unsigned CHANNELS  = 8,
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [31:0]              req_now_time,
   input  logic [RAW_BITS-1:0]      req_raw_pressed,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MASK_BITS-1:0]     rsp_stable_mask,
   output logic [MASK_BITS-1:0]     rsp_press_events,
   output logic                     rsp_tone_valid,
   output logic [TONE_CH_BITS-1:0]  rsp_tone_channel,
   output logic [TONE_HZ_BITS-1:0]  rsp_tone_hz,
   // configuration
   input  logic                     csr_write_enable,
   input  logic [DEBOUNCE_BITS-1:0] csr_write_data
);

   // input register
   logic                     req_valid_ff, req_valid_in;
   logic [31:0]              now_ff;
   logic [RAW_BITS-1:0]      raw_ff;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0]     stable_mask_ff, stable_mask_in;
   logic [MASK_BITS-1:0]     press_events_ff, press_events_in;
   logic                     tone_valid_ff, tone_valid_in;
   logic [TONE_CH_BITS-1:0]  tone_channel_ff, tone_channel_in;
   logic [TONE_HZ_BITS-1:0]  tone_hz_ff, tone_hz_in;

   logic [DEBOUNCE_BITS-1:0] debounce_ff;

   // pipeline control
   logic                     rsp_free;     // response register can take a new beat
   logic                     step;         // the held sample is processed this cycle

   // datapath
   logic [TIME_BITS+31:0]    now_wide;
   logic [TIME_BITS-1:0]     now;
   logic [CHANNELS+RAW_BITS-1:0] raw_wide;
   chan_status_type          status [CHANNELS];
   logic [CHANNELS+MASK_BITS-1:0] stable_vec;
   logic [CHANNELS+MASK_BITS-1:0] press_vec;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;

   // timestamp wraps at TIME_BITS: truncate or zero-extend the 32-bit port
   assign now_wide = {{TIME_BITS{1'b0}}, now_ff};
   assign now      = now_wide[TIME_BITS-1:0];
   // channels above the raw input width see a released button
   assign raw_wide = {{CHANNELS{1'b0}}, raw_ff};

   // one debounce slice per button, all updated in the same cycle
   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      mbd_channel #(
         .TIME_BITS(TIME_BITS)
      ) u_chan (
         .clock        (clock),
         .reset        (reset),
         .step         (step),
         .now          (now),
         .raw          (raw_wide[g]),
         .debounce_time(debounce_ff),
         .status       (status[g])
      );
   end

   always_comb begin
      stable_vec      = '0;
      press_vec       = '0;
      tone_valid_in   = 1'b0;
      tone_channel_in = '0;
      // last press wins, so scan upward and keep overwriting
      for (int i = 0; i < CHANNELS; i++) begin
         stable_vec[i] = status[i].stable;
         press_vec[i]  = status[i].press;
         if (status[i].press) begin
            tone_valid_in   = 1'b1;
            tone_channel_in = TONE_CH_BITS'(i);
         end
      end
      // masks report only the low eight buttons
      stable_mask_in  = stable_vec[MASK_BITS-1:0];
      press_events_in = press_vec[MASK_BITS-1:0];
      tone_hz_in      = tone_valid_in ? tone_lookup(tone_channel_in) : '0;
   end

   // input register loads whenever it is not holding a stalled beat
   assign req_valid_in = req_stall ? req_valid_ff : req_valid;
   assign rsp_valid_in = rsp_free ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         debounce_ff  <= DEBOUNCE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            debounce_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         now_ff <= req_now_time;
         raw_ff <= req_raw_pressed;
      end
      if (step) begin
         stable_mask_ff  <= stable_mask_in;
         press_events_ff <= press_events_in;
         tone_valid_ff   <= tone_valid_in;
         tone_channel_ff <= tone_channel_in;
         tone_hz_ff      <= tone_hz_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stable_mask  = stable_mask_ff;
   assign rsp_press_events = press_events_ff;
   assign rsp_tone_valid   = tone_valid_ff;
   assign rsp_tone_channel = tone_channel_ff;
   assign rsp_tone_hz      = tone_hz_ff;

   // a press event always shows up in the stable mask of the same beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((press_events_ff & ~stable_mask_ff) == '0))
      else $error("press event on a button that is not stably pressed");

   // any reported press selects a tone
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (press_events_ff != '0)) |-> tone_valid_ff)
      else $error("press event without tone choice");

   // no tone means zero channel and zero frequency
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !tone_valid_ff) |-> (tone_hz_ff == '0 && tone_channel_ff == '0))
      else $error("tone fields set without a new press");

   // a held sample is never dropped while the response side is free
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_free) |=> rsp_valid_ff)
      else $error("processed sample lost on its way to the response register");

endmodule

[bench/tb.sv]
module tb;
   import mbd_pkg::*;

   // one raw sample offered to the debouncer
   typedef struct packed {
      logic [31:0]         stamp;
      logic [RAW_BITS-1:0] levels;
   } button_sample_type;

   // what the block should report for one sample
   typedef struct packed {
      logic [MASK_BITS-1:0]    held;
      logic [MASK_BITS-1:0]    pressed;
      logic                    tone_on;
      logic [TONE_CH_BITS-1:0] tone_ch;
      logic [TONE_HZ_BITS-1:0] tone_hz;
   } button_report_type;

   // tone per button, button 0 in the low slice
   localparam logic [8*TONE_HZ_BITS-1:0] PITCH_TABLE = {
      11'd1047, 11'd988, 11'd880, 11'd784, 11'd698, 11'd659, 11'd587, 11'd523
   };
   localparam int HOLD_CYCLES = 64;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [31:0]              req_now_time = '0;
   logic [RAW_BITS-1:0]      req_raw_pressed = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MASK_BITS-1:0]     rsp_stable_mask;
   logic [MASK_BITS-1:0]     rsp_press_events;
   logic                     rsp_tone_valid;
   logic [TONE_CH_BITS-1:0]  rsp_tone_channel;
   logic [TONE_HZ_BITS-1:0]  rsp_tone_hz;
   logic                     csr_write_enable = 1'b0;
   logic [DEBOUNCE_BITS-1:0] csr_write_data = '0;

   // local copy of the per-button state and the debounce setting
   logic                     raw_seen [8];
   logic [31:0]              flip_stamp [8];
   logic                     settled [8];
   logic [DEBOUNCE_BITS-1:0] debounce_ticks;

   button_sample_type pending_samples [$];
   button_report_type expected_reports [$];

   int unsigned mismatches = 0;
   bit          req_taken = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_asked = 0;
   int          hold_granted = 0;
   int          hold_left = 0;

   // time walk and button levels for the random part
   logic [31:0]         tick;
   logic [RAW_BITS-1:0] levels;

   multi_button_debounce_press_event dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_time     (req_now_time),
      .req_raw_pressed  (req_raw_pressed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_stable_mask  (rsp_stable_mask),
      .rsp_press_events (rsp_press_events),
      .rsp_tone_valid   (rsp_tone_valid),
      .rsp_tone_channel (rsp_tone_channel),
      .rsp_tone_hz      (rsp_tone_hz),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // per-button debounce: a raw change restarts the wait, a level that has held for
   // debounce_ticks (wrapping difference) becomes stable
   function automatic button_report_type debounce_predict(input button_sample_type s);
      button_report_type rep;
      logic [31:0]       elapsed;
      rep = '0;
      for (int i = 0; i < 8; i++) begin
         if (s.levels[i] != raw_seen[i]) begin
            raw_seen[i] = s.levels[i];
            flip_stamp[i] = s.stamp;
         end
         elapsed = s.stamp - flip_stamp[i];
         if (elapsed >= {16'd0, debounce_ticks}) begin
            // released to pressed: later buttons overwrite the tone choice
            if (s.levels[i] && !settled[i]) begin
               rep.pressed[i] = 1'b1;
               rep.tone_on = 1'b1;
               rep.tone_ch = i[TONE_CH_BITS-1:0];
               rep.tone_hz = PITCH_TABLE[i*TONE_HZ_BITS +: TONE_HZ_BITS];
            end
            settled[i] = s.levels[i];
         end
         rep.held[i] = settled[i];
      end
      return rep;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // request side: note the accepted beat and queue its expected response
   always @(posedge clock) begin : request_tap
      button_sample_type seen;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         seen.stamp = req_now_time;
         seen.levels = req_raw_pressed;
         expected_reports.push_back(debounce_predict(seen));
      end
   end

   // driver: new beat only once the previous one went through, payload held while stalled
   always @(negedge clock) begin : sample_driver
      button_sample_type beat;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_now_time <= beat.stamp;
            req_raw_pressed <= beat.levels;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random per phase, or a long hold-off when one is asked for
   always @(negedge clock) begin : stall_driver
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_asked != hold_granted) begin
         hold_granted++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // response side: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin : report_check
      button_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("response beat with no expectation waiting");
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("stable_mask", 32'(want.held), 32'(rsp_stable_mask));
            check_field("press_events", 32'(want.pressed), 32'(rsp_press_events));
            check_field("tone_valid", 32'(want.tone_on), 32'(rsp_tone_valid));
            check_field("tone_channel", 32'(want.tone_ch), 32'(rsp_tone_channel));
            check_field("tone_hz", 32'(want.tone_hz), 32'(rsp_tone_hz));
         end
      end
   end

   task automatic offer_sample(input logic [31:0] stamp, input logic [RAW_BITS-1:0] raw);
      button_sample_type s;
      s.stamp = stamp;
      s.levels = raw;
      pending_samples.push_back(s);
   endtask

   // everything sent and everything answered, then a pause for pipeline slack
   task automatic drain();
      while (pending_samples.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one setting of the debounce time, one idling and stall mode, a burst of button activity
   task automatic run_phase(input logic [DEBOUNCE_BITS-1:0] setting, input int idle,
                            input int stall, input int count, input bit squeeze);
      logic [RAW_BITS-1:0] flips;
      int                  span;
      int                  step;
      int                  pick;
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      debounce_ticks = setting;
      send_idle_pct = idle;
      stall_pct = stall;
      span = int'(setting);
      // start anywhere, or just short of the wrap point
      if ($urandom_range(1) != 0)
         tick = $urandom();
      else
         tick = 32'hFFFF_FFFF - $urandom_range(20 * span + 200, 0);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            // noise: arbitrary timestamp and levels
            offer_sample($urandom(), RAW_BITS'($urandom_range(255)));
         end else begin
            // mostly short steps so bounces stay unsettled, some long enough to settle
            pick = $urandom_range(9);
            if (pick < 6)
               step = $urandom_range(span / 2 + 1, 0);
            else if (pick < 9)
               step = $urandom_range(span * 2 + 2, span / 2);
            else
               step = $urandom_range(span + 4, span);
            tick = tick + step;
            flips = '0;
            for (int b = 0; b < RAW_BITS; b++)
               if ($urandom_range(5) == 0) flips[b] = 1'b1;
            levels = levels ^ flips;
            offer_sample(tick, levels);
         end
      end
      // long receiver hold-offs while the sender keeps offering, twice
      if (squeeze) begin
         for (int k = 1; k <= 2; k++) begin
            while (pending_samples.size() > count - 100 * k) @(posedge clock);
            hold_asked++;
         end
      end
   endtask

   initial begin : test_sequence
      for (int i = 0; i < 8; i++) begin
         raw_seen[i] = 1'b0;
         flip_stamp[i] = '0;
         settled[i] = 1'b0;
      end
      debounce_ticks = 16'd8;
      levels = '0;
      tick = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, debounce time at its reset value of 8
      offer_sample(32'd0, 8'h00);
      offer_sample(32'd1, 8'hFF);
      offer_sample(32'd9, 8'hFF);       // all settle at once, highest button wins the tone
      offer_sample(32'd10, 8'h00);
      offer_sample(32'd20, 8'h00);
      // each button alone, so every tone shows up
      for (int ch = 0; ch < 8; ch++) begin
         offer_sample(32'd21 + 9 * ch, 8'h01 << ch);
         offer_sample(32'd29 + 9 * ch, 8'h01 << ch);
      end
      // press across the timestamp wrap, button 7 already held
      offer_sample(32'hFFFF_FFF9, 8'h81);
      offer_sample(32'd1, 8'h81);
      offer_sample(32'hFFFF_FFFF, 8'h00);

      run_phase(16'd5, 0, 0, 300, 1'b0);
      run_phase(16'd0, 83, 0, 300, 1'b0);         // zero debounce: settles on the same beat
      run_phase(16'hFFFF, 0, 83, 300, 1'b0);
      run_phase(16'd1, 15, 15, 300, 1'b0);
      run_phase(DEBOUNCE_BITS'($urandom_range(40, 2)), 0, 0, 300, 1'b1);
      run_phase(16'd8, 15, 15, 300, 1'b0);
      drain();
      repeat (6) @(posedge clock);

      if (expected_reports.size() != 0) begin
         $error("%0d expected responses never arrived", expected_reports.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
rtl/mbd_pkg.sv
rtl/mbd_channel.sv
rtl/multi_button_debounce_press_event.sv
bench/tb.sv
